[rtl/ddu_pkg.sv]
// Shared types and constants for the demons displacement update block.
// Used by ddu_lane, ddu_merge and demons_displacement_update_top; no dependencies.
`default_nettype none
package ddu_pkg;

  localparam int unsigned MAX_DIM = 3;

  localparam logic [1:0] CMD_FWD   = 2'd0;
  localparam logic [1:0] CMD_INV   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] CFG_INV_NORM  = 3'd0;
  localparam logic [2:0] CFG_ROB_THR   = 3'd1;
  localparam logic [2:0] CFG_DIFF_THR  = 3'd2;
  localparam logic [2:0] CFG_DEN_THR   = 3'd3;
  localparam logic [2:0] CFG_USE_MGRAD = 3'd4;
  localparam logic [2:0] CFG_USE_SSD   = 3'd5;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_GSQ,
    LOP_NUM,
    LOP_DINIT,
    LOP_DSTEP,
    LOP_RES,
    LOP_USQ
  } lane_op_e;

  typedef struct packed {
    logic gsum_en;
    logic chg_en;
    logic clear;
  } merge_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_DEN1,
    S_DEN2,
    S_CHK,
    S_DINIT,
    S_DIV,
    S_RES,
    S_USQ,
    S_CHG,
    S_OUT
  } ctrl_state_e;

endpackage
`default_nettype wire

[rtl/ddu_lane.sv]
// One component lane: gradient square, numerator product, bit-serial divider
// and saturated signed result. Depends on ddu_pkg.
`default_nettype none
module ddu_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ddu_pkg::lane_op_e op_i,
  input  wire logic [31:0]       smag_i,
  input  wire logic              sneg_i,
  input  wire logic [31:0]       gmag_i,
  input  wire logic              gneg_i,
  input  wire logic [63:0]       den_i,
  output logic [63:0]            gsq_o,
  output logic [31:0]            u_o,
  output logic [63:0]            usq_o,
  output logic                   sat_o
);

  localparam int unsigned DW = 64 + FRAC_BITS;

  logic [31:0]    ma, mb;
  logic [63:0]    prod;
  logic [63:0]    gsq_q, n_q, rem_q, usq_q;
  logic [31:0]    dlo_q, q_q, u_q, um_q;
  logic           big_q, sat_q;
  logic [DW-1:0]  dvd;
  logic [63:0]    hi64;
  logic [64:0]    t, diff;
  logic           ge, neg, over;
  logic [31:0]    limit, qs;

  always_comb begin
    unique case (op_i)
      ddu_pkg::LOP_GSQ: begin
        ma = gmag_i;
        mb = gmag_i;
      end
      ddu_pkg::LOP_NUM: begin
        ma = smag_i;
        mb = gmag_i;
      end
      ddu_pkg::LOP_USQ: begin
        ma = um_q;
        mb = um_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod = 64'(ma) * 64'(mb);
  end

  always_comb begin
    dvd   = {n_q, {FRAC_BITS{1'b0}}};
    hi64  = 64'(dvd[DW-1:32]);
    t     = {rem_q, dlo_q[31]};
    diff  = t - {1'b0, den_i};
    ge    = (t >= {1'b0, den_i});
    neg   = (sneg_i != gneg_i) && (n_q != '0);
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    over  = big_q || (q_q > limit);
    qs    = over ? limit : q_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsq_q <= '0;
      n_q   <= '0;
      rem_q <= '0;
      usq_q <= '0;
      dlo_q <= '0;
      q_q   <= '0;
      u_q   <= '0;
      um_q  <= '0;
      big_q <= 1'b0;
      sat_q <= 1'b0;
    end else begin
      unique case (op_i)
        ddu_pkg::LOP_GSQ: gsq_q <= prod;
        ddu_pkg::LOP_NUM: n_q <= prod;
        ddu_pkg::LOP_DINIT: begin
          big_q <= (hi64 >= den_i);
          rem_q <= hi64;
          dlo_q <= dvd[31:0];
          q_q   <= '0;
        end
        ddu_pkg::LOP_DSTEP: begin
          rem_q <= ge ? diff[63:0] : t[63:0];
          dlo_q <= {dlo_q[30:0], 1'b0};
          q_q   <= {q_q[30:0], ge};
        end
        ddu_pkg::LOP_RES: begin
          u_q   <= neg ? (32'd0 - qs) : qs;
          um_q  <= qs;
          sat_q <= over;
        end
        ddu_pkg::LOP_USQ: usq_q <= prod;
        default: ;
      endcase
    end
  end

  assign gsq_o = gsq_q;
  assign u_o   = u_q;
  assign usq_o = usq_q;
  assign sat_o = sat_q;

endmodule
`default_nettype wire

[rtl/ddu_merge.sv]
// Merging stage: sums the lanes' gradient squares and accumulates the
// squared update components with saturation. Depends on ddu_pkg.
`default_nettype none
module ddu_merge (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ddu_pkg::merge_ctl_t ctl_i,
  input  wire logic [63:0]         gsq_i [ddu_pkg::MAX_DIM],
  input  wire logic [63:0]         usq_i [ddu_pkg::MAX_DIM],
  output logic [63:0]              gsum_o,
  output logic [63:0]              sq_change_o,
  output logic                     chg_sat_o
);

  logic [65:0] gs;
  logic [66:0] tot;
  logic [63:0] gsum_q, chg_q;
  logic        chg_sat_q;

  always_comb begin
    gs  = '0;
    tot = 67'(chg_q);
    for (int j = 0; j < ddu_pkg::MAX_DIM; j++) begin
      gs  = gs + 66'(gsq_i[j]);
      tot = tot + 67'(usq_i[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.gsum_en) begin
      gsum_q <= gs[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chg_q     <= '0;
      chg_sat_q <= 1'b0;
    end else if (ctl_i.clear) begin
      chg_q     <= '0;
      chg_sat_q <= 1'b0;
    end else if (ctl_i.chg_en) begin
      chg_q     <= (tot[66:64] != '0) ? '1 : tot[63:0];
      chg_sat_q <= (tot[66:64] != '0);
    end
  end

  assign gsum_o      = gsum_q;
  assign sq_change_o = chg_q;
  assign chg_sat_o   = chg_sat_q;

endmodule
`default_nettype wire

[rtl/demons_displacement_update_top.sv]
// Top level of the demons displacement update block: control sequencer,
// front-end arithmetic, accumulators and output register.
// Depends on ddu_pkg, ddu_lane and ddu_merge.
//
// Usage: one voxel item enters on the input channel (in_valid_i, in_stall_o)
// and one result item leaves on the output channel (out_valid_o,
// out_stall_i). An update item runs from acceptance through the divide to a
// loaded output register; when a threshold zeroes the update it skips the
// divide, and clear and unused commands go straight to the output step.
// The length of an update is set by the 32-step restoring dividers, one per
// component lane, which run side by side and produce one quotient bit a
// cycle, plus the shared 32 by 32 multiplier that forms the denominator in
// three passes. One item is worked on at a time; a new item is taken once
// the previous one has reached the output register. When the receiver
// stalls, the result holds in the output register and the sequencer waits
// at its last step. Reset clears the accumulators and loads the register
// defaults; configuration is to be written through cfg_we_i, cfg_idx_i and
// cfg_data_i only while the block is idle; the block does not enforce this.
`default_nettype none
module demons_displacement_update_top #(
  parameter int unsigned DIMENSION = 3,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [31:0] fixed_value_i,
  input  wire logic signed [31:0] moving_value_i,
  input  wire logic signed [31:0] fixed_grad_x_i,
  input  wire logic signed [31:0] fixed_grad_y_i,
  input  wire logic signed [31:0] fixed_grad_z_i,
  input  wire logic signed [31:0] moving_grad_x_i,
  input  wire logic signed [31:0] moving_grad_y_i,
  input  wire logic signed [31:0] moving_grad_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      update_x_o,
  output logic signed [31:0]      update_y_o,
  output logic signed [31:0]      update_z_o,
  output logic                    was_zeroed_o,
  output logic                    saturated_o,
  output logic [63:0]             total_sq_difference_o,
  output logic [63:0]             total_sq_change_o,
  output logic [63:0]             total_energy_o,
  output logic [31:0]             voxels_processed_o
);

  localparam int unsigned ND = ddu_pkg::MAX_DIM;

  ddu_pkg::ctrl_state_e state_q, state_d;
  ddu_pkg::lane_op_e    lane_op;
  ddu_pkg::merge_ctl_t  mctl;

  logic [31:0] inv_norm_q, den_thr_q;
  logic [30:0] rob_thr_q, diff_thr_q;
  logic        use_mgrad_q, use_ssd_q;

  logic [63:0] sq_diff_q, energy_q;
  logic [31:0] count_q;
  logic [4:0]  cnt_q;

  logic               fwd_q, div_q, zeroed_q, sat_q;
  logic signed [31:0] fv_q, mv_q;
  logic signed [31:0] fg_q [ND];
  logic signed [31:0] mg_q [ND];
  logic [31:0]        gmag_q [ND];
  logic               gneg_q [ND];
  logic [31:0]        smag_q;
  logic               sneg_q;
  logic [63:0]        ssq_q, pl_q, ph_q, ms_q, den_q;

  logic signed [32:0] sdiff, gsum33;
  logic signed [31:0] speed, gv;
  logic [31:0]        smag_c;
  logic               prep_sat;
  logic [31:0]        gmag_c [ND];
  logic               gneg_c [ND];

  logic [31:0] ma, mb;
  logic [63:0] prod;
  logic [95:0] p96;
  logic [63:0] ms_c;
  logic [64:0] den_sum, sd_sum, en_sum;

  logic [63:0] lane_gsq [ND];
  logic [63:0] lane_usq [ND];
  logic [31:0] lane_u   [ND];
  logic        lane_sat [ND];
  logic [63:0] gsum, sq_change;
  logic        chg_sat, lanes_sat, zero_c;

  logic signed [31:0] upd_q [ND];
  logic               out_valid_q, out_zeroed_q, out_sat_q;
  logic [63:0]        out_sd_q, out_chg_q, out_en_q;
  logic [31:0]        out_cnt_q;

  logic in_acc, out_free;

  assign in_stall_o = (state_q != ddu_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_norm_q  <= 32'd65536;
      rob_thr_q   <= '0;
      diff_thr_q  <= 31'd66;
      den_thr_q   <= 32'd1;
      use_mgrad_q <= 1'b0;
      use_ssd_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ddu_pkg::CFG_INV_NORM:  inv_norm_q  <= cfg_data_i;
        ddu_pkg::CFG_ROB_THR:   rob_thr_q   <= cfg_data_i[30:0];
        ddu_pkg::CFG_DIFF_THR:  diff_thr_q  <= cfg_data_i[30:0];
        ddu_pkg::CFG_DEN_THR:   den_thr_q   <= cfg_data_i;
        ddu_pkg::CFG_USE_MGRAD: use_mgrad_q <= cfg_data_i[0];
        ddu_pkg::CFG_USE_SSD:   use_ssd_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Speed and gradient selection with saturation.
  always_comb begin
    prep_sat = 1'b0;
    sdiff    = fwd_q ? (33'(fv_q) - 33'(mv_q)) : (33'(mv_q) - 33'(fv_q));
    if (sdiff > 33'sd2147483647) begin
      speed    = 32'sh7FFF_FFFF;
      prep_sat = 1'b1;
    end else if (sdiff < -33'sd2147483648) begin
      speed    = 32'sh8000_0000;
      prep_sat = 1'b1;
    end else begin
      speed = sdiff[31:0];
    end
    smag_c = speed[31] ? (32'd0 - speed) : speed;
    for (int j = 0; j < ND; j++) begin
      gsum33 = 33'(fg_q[j]) + 33'(mg_q[j]);
      gv     = '0;
      if (j < DIMENSION) begin
        if (!fwd_q) begin
          gv = mg_q[j];
        end else if (!use_mgrad_q) begin
          gv = fg_q[j];
        end else if (gsum33 > 33'sd2147483647) begin
          gv       = 32'sh7FFF_FFFF;
          prep_sat = 1'b1;
        end else if (gsum33 < -33'sd2147483648) begin
          gv       = 32'sh8000_0000;
          prep_sat = 1'b1;
        end else begin
          gv = gsum33[31:0];
        end
      end
      gneg_c[j] = gv[31];
      gmag_c[j] = gv[31] ? (32'd0 - gv) : gv;
    end
  end

  always_comb begin
    unique case (state_q)
      ddu_pkg::S_MUL1: begin
        ma = smag_q;
        mb = smag_q;
      end
      ddu_pkg::S_MUL2: begin
        ma = ssq_q[31:0];
        mb = inv_norm_q;
      end
      ddu_pkg::S_MUL3: begin
        ma = ssq_q[63:32];
        mb = inv_norm_q;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
    prod    = 64'(ma) * 64'(mb);
    p96     = {ph_q, 32'd0} + 96'(pl_q);
    ms_c    = (p96[95:64+FRAC_BITS] != '0) ? '1 : p96[63+FRAC_BITS:FRAC_BITS];
    den_sum = 65'(ms_q) + 65'(gsum);
    sd_sum  = 65'(sq_diff_q) + 65'(ssq_q);
    en_sum  = 65'(energy_q) + 65'(ssq_q);
    zero_c  = (smag_q < 32'(diff_thr_q)) || (den_q < (64'(den_thr_q) << FRAC_BITS))
              || (den_q == '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ddu_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = (cmd_i == ddu_pkg::CMD_FWD || cmd_i == ddu_pkg::CMD_INV)
                    ? ddu_pkg::S_PREP : ddu_pkg::S_OUT;
        end
      end
      ddu_pkg::S_PREP:  state_d = ddu_pkg::S_MUL1;
      ddu_pkg::S_MUL1:  state_d = ddu_pkg::S_MUL2;
      ddu_pkg::S_MUL2:  state_d = ddu_pkg::S_MUL3;
      ddu_pkg::S_MUL3:  state_d = ddu_pkg::S_DEN1;
      ddu_pkg::S_DEN1:  state_d = ddu_pkg::S_DEN2;
      ddu_pkg::S_DEN2:  state_d = ddu_pkg::S_CHK;
      ddu_pkg::S_CHK:   state_d = zero_c ? ddu_pkg::S_OUT : ddu_pkg::S_DINIT;
      ddu_pkg::S_DINIT: state_d = ddu_pkg::S_DIV;
      ddu_pkg::S_DIV: begin
        if (cnt_q == '1) begin
          state_d = ddu_pkg::S_RES;
        end
      end
      ddu_pkg::S_RES:   state_d = ddu_pkg::S_USQ;
      ddu_pkg::S_USQ:   state_d = ddu_pkg::S_CHG;
      ddu_pkg::S_CHG:   state_d = ddu_pkg::S_OUT;
      ddu_pkg::S_OUT: begin
        if (out_free) begin
          state_d = ddu_pkg::S_IDLE;
        end
      end
      default: state_d = ddu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    lane_op      = ddu_pkg::LOP_NONE;
    mctl.gsum_en = 1'b0;
    mctl.chg_en  = 1'b0;
    mctl.clear   = in_acc && (cmd_i == ddu_pkg::CMD_CLEAR);
    unique case (state_q)
      ddu_pkg::S_MUL1:  lane_op = ddu_pkg::LOP_GSQ;
      ddu_pkg::S_MUL2: begin
        lane_op      = ddu_pkg::LOP_NUM;
        mctl.gsum_en = 1'b1;
      end
      ddu_pkg::S_DINIT: lane_op = ddu_pkg::LOP_DINIT;
      ddu_pkg::S_DIV:   lane_op = ddu_pkg::LOP_DSTEP;
      ddu_pkg::S_RES:   lane_op = ddu_pkg::LOP_RES;
      ddu_pkg::S_USQ:   lane_op = ddu_pkg::LOP_USQ;
      ddu_pkg::S_CHG:   mctl.chg_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ddu_pkg::S_IDLE;
      cnt_q     <= '0;
      sq_diff_q <= '0;
      energy_q  <= '0;
      count_q   <= '0;
      div_q     <= 1'b0;
      zeroed_q  <= 1'b0;
      sat_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ddu_pkg::S_IDLE: begin
          if (in_acc) begin
            div_q    <= 1'b0;
            zeroed_q <= 1'b0;
            sat_q    <= 1'b0;
            if (cmd_i == ddu_pkg::CMD_CLEAR) begin
              sq_diff_q <= '0;
              energy_q  <= '0;
              count_q   <= '0;
            end
          end
        end
        ddu_pkg::S_PREP: sat_q <= prep_sat;
        ddu_pkg::S_MUL2: begin
          sq_diff_q <= sd_sum[64] ? '1 : sd_sum[63:0];
          if (fwd_q) begin
            energy_q <= en_sum[64] ? '1 : en_sum[63:0];
          end
          if (count_q != '1) begin
            count_q <= count_q + 32'd1;
          end
          sat_q <= sat_q || sd_sum[64] || (fwd_q && en_sum[64]) || (count_q == '1);
        end
        ddu_pkg::S_CHK: begin
          zeroed_q <= zero_c;
          div_q    <= !zero_c;
        end
        ddu_pkg::S_DINIT: cnt_q <= '0;
        ddu_pkg::S_DIV:   cnt_q <= cnt_q + 5'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ddu_pkg::S_IDLE: begin
        if (in_acc) begin
          fwd_q    <= (cmd_i == ddu_pkg::CMD_FWD);
          fv_q     <= fixed_value_i;
          mv_q     <= moving_value_i;
          fg_q[0]  <= fixed_grad_x_i;
          fg_q[1]  <= fixed_grad_y_i;
          fg_q[2]  <= fixed_grad_z_i;
          mg_q[0]  <= moving_grad_x_i;
          mg_q[1]  <= moving_grad_y_i;
          mg_q[2]  <= moving_grad_z_i;
        end
      end
      ddu_pkg::S_PREP: begin
        if (smag_c < 32'(rob_thr_q)) begin
          smag_q <= '0;
          sneg_q <= 1'b0;
        end else begin
          smag_q <= smag_c;
          sneg_q <= speed[31];
        end
        gmag_q <= gmag_c;
        gneg_q <= gneg_c;
      end
      ddu_pkg::S_MUL1: ssq_q <= prod;
      ddu_pkg::S_MUL2: pl_q <= prod;
      ddu_pkg::S_MUL3: ph_q <= prod;
      ddu_pkg::S_DEN1: ms_q <= ms_c;
      ddu_pkg::S_DEN2: begin
        if (fwd_q && use_ssd_q) begin
          den_q <= 64'd1 << (2 * FRAC_BITS);
        end else begin
          den_q <= den_sum[64] ? '1 : den_sum[63:0];
        end
      end
      default: ;
    endcase
  end

  for (genvar j = 0; j < ND; j++) begin : g_lane
    if (j < DIMENSION) begin : g_on
      ddu_lane #(
        .FRAC_BITS(FRAC_BITS)
      ) u_lane (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .op_i   (lane_op),
        .smag_i (smag_q),
        .sneg_i (sneg_q),
        .gmag_i (gmag_q[j]),
        .gneg_i (gneg_q[j]),
        .den_i  (den_q),
        .gsq_o  (lane_gsq[j]),
        .u_o    (lane_u[j]),
        .usq_o  (lane_usq[j]),
        .sat_o  (lane_sat[j])
      );
    end else begin : g_off
      assign lane_gsq[j] = '0;
      assign lane_u[j]   = '0;
      assign lane_usq[j] = '0;
      assign lane_sat[j] = 1'b0;
    end
  end

  ddu_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mctl),
    .gsq_i       (lane_gsq),
    .usq_i       (lane_usq),
    .gsum_o      (gsum),
    .sq_change_o (sq_change),
    .chg_sat_o   (chg_sat)
  );

  always_comb begin
    lanes_sat = 1'b0;
    for (int j = 0; j < ND; j++) begin
      lanes_sat = lanes_sat || lane_sat[j];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ddu_pkg::S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ddu_pkg::S_OUT && out_free) begin
      for (int j = 0; j < ND; j++) begin
        upd_q[j] <= div_q ? lane_u[j] : '0;
      end
      out_zeroed_q <= zeroed_q;
      out_sat_q    <= sat_q || (div_q && (lanes_sat || chg_sat));
      out_sd_q     <= sq_diff_q;
      out_chg_q    <= sq_change;
      out_en_q     <= energy_q;
      out_cnt_q    <= count_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign update_x_o            = upd_q[0];
  assign update_y_o            = upd_q[1];
  assign update_z_o            = upd_q[2];
  assign was_zeroed_o          = out_zeroed_q;
  assign saturated_o           = out_sat_q;
  assign total_sq_difference_o = out_sd_q;
  assign total_sq_change_o     = out_chg_q;
  assign total_energy_o        = out_en_q;
  assign voxels_processed_o    = out_cnt_q;

endmodule
`default_nettype wire
